>>> src/pcpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcpd_pkg
// Shared types and fixed widths of the PN correlator and peak detector.
// ----------------------------------------------------------------------------
package pcpd_pkg;

   // Fixed widths of the result fields and of the detector state.
   localparam int ENERGY_W = 36;
   localparam int AVG_W    = 52;
   localparam int POS_W    = 48;
   localparam int LOOK_W   = 10;
   localparam int CSR_IDX_W = 8;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PN_PATTERN = 8'd0,
      CSR_ALPHA      = 8'd1,
      CSR_RISE       = 8'd2,
      CSR_LOOK_AHEAD = 8'd3
   } csr_index_type;

   // Detector settings handed from the register bank to the back end.
   typedef struct packed {
      logic [15:0]       alpha;
      logic [15:0]       rise;
      logic [LOOK_W-1:0] look;
   } det_cfg_type;

endpackage

>>> src/pcpd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcpd_front
// Sample delay line and tap-serial PN correlator producing the energy.
// ----------------------------------------------------------------------------
module pcpd_front #(
   parameter int TAPS        = 64,
   parameter int OVERSAMPLE  = 4,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [SAMPLE_BITS-1:0] in_i,
   input  logic signed [SAMPLE_BITS-1:0] in_q,
   input  logic [63:0]                   pn_pattern,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [2*SAMPLE_BITS+pcpd_pkg::ENERGY_W-1:0] out_data
);
   import pcpd_pkg::*;

   localparam int DEPTH = TAPS * OVERSAMPLE;
   localparam int ACC_W = SAMPLE_BITS + $clog2(TAPS) + 1;
   localparam int SQ_W  = 2 * ACC_W;
   localparam int EXT_W = (SQ_W + 1 > ENERGY_W + 1) ? SQ_W + 1 : ENERGY_W + 1;
   localparam int CNT_W = (TAPS > 1) ? $clog2(TAPS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOAD, ST_ACC, ST_SQUARE, ST_EMIT
   } state_type;

   state_type                     state_ff;
   logic signed [SAMPLE_BITS-1:0] dl_i_ff [DEPTH];
   logic signed [SAMPLE_BITS-1:0] dl_q_ff [DEPTH];
   logic signed [SAMPLE_BITS-1:0] snap_i_ff [TAPS];
   logic signed [SAMPLE_BITS-1:0] snap_q_ff [TAPS];
   logic [TAPS-1:0]               pat_ff;
   logic [CNT_W-1:0]              cnt_ff;
   logic signed [ACC_W-1:0]       acc_i_ff, acc_q_ff;
   logic [SQ_W-1:0]               sq_i_ff, sq_q_ff;
   logic [SAMPLE_BITS-1:0]        pass_i_ff, pass_q_ff;
   logic                          out_valid_ff;
   logic [2*SAMPLE_BITS+ENERGY_W-1:0] out_data_ff;

   logic signed [SQ_W-1:0]        prod_i_in, prod_q_in;
   logic [EXT_W-1:0]              sum_in;
   logic [ENERGY_W-1:0]           energy_in;
   logic                          accept;
   logic                          slot_free;
   logic                          emit;

   assign in_ready  = (state_ff == ST_IDLE);
   assign accept    = in_valid && in_ready;
   assign slot_free = !out_valid_ff || out_ready;
   assign emit      = (state_ff == ST_EMIT) && slot_free;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   // Squares of the two correlation sums and the saturated energy.
   always_comb begin
      prod_i_in = acc_i_ff * acc_i_ff;
      prod_q_in = acc_q_ff * acc_q_ff;
      sum_in    = EXT_W'(sq_i_ff) + EXT_W'(sq_q_ff);
      if (sum_in[EXT_W-1:ENERGY_W] != '0) begin
         energy_in = '1;
      end else begin
         energy_in = sum_in[ENERGY_W-1:0];
      end
   end

   // Delay line: shifts once per accepted item, newest sample at age zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DEPTH; k++) begin
            dl_i_ff[k] <= '0;
            dl_q_ff[k] <= '0;
         end
      end else if (accept) begin
         dl_i_ff[0] <= in_i;
         dl_q_ff[0] <= in_q;
         for (int k = 1; k < DEPTH; k++) begin
            dl_i_ff[k] <= dl_i_ff[k-1];
            dl_q_ff[k] <= dl_q_ff[k-1];
         end
      end
   end

   // Sequencer: snapshot the taps, accumulate one tap a cycle, square, emit.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_ready && !emit) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  pass_i_ff <= in_i;
                  pass_q_ff <= in_q;
                  state_ff  <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               for (int j = 0; j < TAPS; j++) begin
                  snap_i_ff[j] <= dl_i_ff[DEPTH-1-j*OVERSAMPLE];
                  snap_q_ff[j] <= dl_q_ff[DEPTH-1-j*OVERSAMPLE];
               end
               pat_ff   <= pn_pattern[TAPS-1:0];
               acc_i_ff <= '0;
               acc_q_ff <= '0;
               cnt_ff   <= '0;
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               if (pat_ff[0]) begin
                  acc_i_ff <= acc_i_ff + ACC_W'(snap_i_ff[0]);
                  acc_q_ff <= acc_q_ff + ACC_W'(snap_q_ff[0]);
               end else begin
                  acc_i_ff <= acc_i_ff - ACC_W'(snap_i_ff[0]);
                  acc_q_ff <= acc_q_ff - ACC_W'(snap_q_ff[0]);
               end
               for (int j = 0; j < TAPS - 1; j++) begin
                  snap_i_ff[j] <= snap_i_ff[j+1];
                  snap_q_ff[j] <= snap_q_ff[j+1];
               end
               pat_ff <= pat_ff >> 1;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(TAPS - 1)) begin
                  state_ff <= ST_SQUARE;
               end
            end
            ST_SQUARE: begin
               sq_i_ff  <= $unsigned(prod_i_in);
               sq_q_ff  <= $unsigned(prod_q_in);
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (slot_free) begin
                  out_data_ff  <= {pass_i_ff, pass_q_ff, energy_in};
                  out_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

>>> src/pcpd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcpd_queue
// Two-entry queue that decouples the correlator from the detector.
// ----------------------------------------------------------------------------
module pcpd_queue #(
   parameter int WIDTH = 60
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   import pcpd_pkg::*;

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff;
   logic             push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Storage is written at the tail pointer.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

>>> src/pcpd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcpd_back
// Adaptive threshold, peak search and result register.
// ----------------------------------------------------------------------------
module pcpd_back #(
   parameter int TAPS        = 64,
   parameter int OVERSAMPLE  = 4,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   input  pcpd_pkg::det_cfg_type              cfg,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic [2*SAMPLE_BITS+pcpd_pkg::ENERGY_W-1:0] in_data,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic signed [SAMPLE_BITS-1:0]      out_pass_i,
   output logic signed [SAMPLE_BITS-1:0]      out_pass_q,
   output logic [pcpd_pkg::ENERGY_W-1:0]      out_energy,
   output logic [pcpd_pkg::ENERGY_W-1:0]      out_average,
   output logic                               out_found,
   output logic [pcpd_pkg::POS_W-1:0]         out_position
);
   import pcpd_pkg::*;

   localparam int DEPTH = TAPS * OVERSAMPLE;
   localparam int HALF  = AVG_W / 2;
   localparam int EHALF = ENERGY_W / 2;
   localparam int PW    = HALF + 17;
   localparam int THR_W = AVG_W + 17;

   typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DECIDE} state_type;

   state_type              state_ff;
   logic [SAMPLE_BITS-1:0] pass_i_ff, pass_q_ff;
   logic [ENERGY_W-1:0]    energy_ff;
   logic [PW-1:0]          thr_hi_ff, thr_lo_ff, wa_hi_ff, wa_lo_ff;
   logic [EHALF+15:0]      ae_hi_ff, ae_lo_ff;

   logic                   searching_ff;
   logic [AVG_W-1:0]       avg_ff;
   logic [ENERGY_W-1:0]    best_ff;
   logic                   best_valid_ff;
   logic [POS_W-1:0]       best_idx_ff;
   logic [LOOK_W-1:0]      countdown_ff;
   logic [POS_W-1:0]       counter_ff;

   logic                   out_valid_ff;
   logic [SAMPLE_BITS-1:0] out_i_ff, out_q_ff;
   logic [ENERGY_W-1:0]    out_energy_ff, out_avg_ff;
   logic                   out_found_ff;
   logic [POS_W-1:0]       out_pos_ff;

   logic [16:0]            mult_in, weight_in;
   logic [THR_W-1:0]       thr_in, lhs_in, wa_in;
   logic [AVG_W-1:0]       upd_in, avg_in;
   logic                   above_in, found_in, write_in;

   assign in_ready     = (state_ff == ST_IDLE);
   assign out_valid    = out_valid_ff;
   assign out_pass_i   = out_i_ff;
   assign out_pass_q   = out_q_ff;
   assign out_energy   = out_energy_ff;
   assign out_average  = out_avg_ff;
   assign out_found    = out_found_ff;
   assign out_position = out_pos_ff;

   assign mult_in   = 17'd256 + {1'b0, cfg.rise};
   assign weight_in = 17'd65536 - {1'b0, cfg.alpha};
   assign write_in  = (state_ff == ST_DECIDE) && (!out_valid_ff || out_ready);

   // Threshold compare and average update from the registered products.
   always_comb begin
      thr_in   = (THR_W'(thr_hi_ff) << HALF) + THR_W'(thr_lo_ff);
      lhs_in   = THR_W'({energy_ff, 24'd0});
      above_in = lhs_in > thr_in;
      wa_in    = (THR_W'(wa_hi_ff) << HALF) + THR_W'(wa_lo_ff);
      upd_in   = (AVG_W'(ae_hi_ff) << EHALF) + AVG_W'(ae_lo_ff) + wa_in[AVG_W+15:16];
      found_in = searching_ff && best_valid_ff && !(energy_ff > best_ff)
                 && (countdown_ff == '0);
      avg_in   = avg_ff;
      if (!searching_ff) begin
         if (!above_in) begin
            avg_in = upd_in;
         end
      end else if (found_in) begin
         avg_in = AVG_W'({energy_ff, 16'd0});
      end
   end

   // Sequencer, detector state and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         out_valid_ff  <= 1'b0;
         searching_ff  <= 1'b0;
         avg_ff        <= '0;
         best_ff       <= '0;
         best_valid_ff <= 1'b0;
         best_idx_ff   <= '0;
         countdown_ff  <= '0;
         counter_ff    <= '0;
      end else begin
         if (out_ready && !write_in) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (in_valid) begin
                  {pass_i_ff, pass_q_ff, energy_ff} <= in_data;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               thr_hi_ff <= avg_ff[AVG_W-1:HALF] * mult_in;
               thr_lo_ff <= avg_ff[HALF-1:0] * mult_in;
               wa_hi_ff  <= avg_ff[AVG_W-1:HALF] * weight_in;
               wa_lo_ff  <= avg_ff[HALF-1:0] * weight_in;
               ae_hi_ff  <= energy_ff[ENERGY_W-1:EHALF] * cfg.alpha;
               ae_lo_ff  <= energy_ff[EHALF-1:0] * cfg.alpha;
               state_ff  <= ST_DECIDE;
            end
            ST_DECIDE: begin
               if (write_in) begin
                  avg_ff <= avg_in;
                  if (!searching_ff) begin
                     if (above_in) begin
                        searching_ff  <= 1'b1;
                        countdown_ff  <= cfg.look;
                        best_valid_ff <= 1'b0;
                     end
                  end else begin
                     if (!best_valid_ff || energy_ff > best_ff) begin
                        best_ff       <= energy_ff;
                        best_valid_ff <= 1'b1;
                        best_idx_ff   <= counter_ff;
                     end else if (found_in) begin
                        searching_ff <= 1'b0;
                     end
                     if (countdown_ff != '0) begin
                        countdown_ff <= countdown_ff - 1'b1;
                     end
                  end
                  out_valid_ff  <= 1'b1;
                  out_i_ff      <= pass_i_ff;
                  out_q_ff      <= pass_q_ff;
                  out_energy_ff <= energy_ff;
                  out_avg_ff    <= avg_in[AVG_W-1:16];
                  out_found_ff  <= found_in;
                  out_pos_ff    <= found_in ? best_idx_ff + POS_W'(DEPTH) : '0;
                  counter_ff    <= counter_ff + 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_pos_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_found_ff |-> out_pos_ff == '0)
      else $error("peak position set without a peak");
   a_peak_ends_search: assert property (@(posedge clock) disable iff (reset)
      write_in && found_in |=> !searching_ff && out_found_ff)
      else $error("search still active after a declared peak");
   a_search_load: assert property (@(posedge clock) disable iff (reset)
      $rose(searching_ff) |-> countdown_ff == $past(cfg.look) && !best_valid_ff)
      else $error("search started without loading the countdown");
`endif

endmodule

>>> src/pn_correlator_peak_detector.sv
`timescale 1ns / 1ps
// The correlator accepts a new sample only when idle, after the previous one has
// gone through the tap-serial accumulate (one tap per cycle), square and emit
// steps; the detector handles each item in its multiply and decide states.
// Reset (synchronous, active high) clears the delay line, the detector state
// and the configuration registers to their defaults; no clearing pass follows.
// ----------------------------------------------------------------------------
// pn_correlator_peak_detector
// PN matched filter with energy output and an adaptive peak detector.
// ----------------------------------------------------------------------------
module pn_correlator_peak_detector #(
   parameter int TAPS        = 64,
   parameter int OVERSAMPLE  = 4,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [SAMPLE_BITS-1:0]     req_sample_i,
   input  logic signed [SAMPLE_BITS-1:0]     req_sample_q,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]     rsp_pass_i,
   output logic signed [SAMPLE_BITS-1:0]     rsp_pass_q,
   output logic [pcpd_pkg::ENERGY_W-1:0]     rsp_corr_energy,
   output logic [pcpd_pkg::ENERGY_W-1:0]     rsp_running_average,
   output logic                              rsp_peak_found,
   output logic [pcpd_pkg::POS_W-1:0]        rsp_peak_position,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pcpd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [63:0]                       csr_data
);
   import pcpd_pkg::*;

   localparam int QW = 2 * SAMPLE_BITS + ENERGY_W;

   logic [63:0]   pattern_ff;
   det_cfg_type   cfg_ff;
   logic          f_valid, f_ready, b_valid, b_ready;
   logic [QW-1:0] f_data, b_data;

   assign csr_ready = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff   <= '0;
         cfg_ff.alpha <= 16'd655;
         cfg_ff.rise  <= 16'd25600;
         cfg_ff.look  <= LOOK_W'(4);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PN_PATTERN: pattern_ff   <= csr_data;
            CSR_ALPHA:      cfg_ff.alpha <= csr_data[15:0];
            CSR_RISE:       cfg_ff.rise  <= csr_data[15:0];
            CSR_LOOK_AHEAD: cfg_ff.look  <= csr_data[LOOK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Correlator front end.
   pcpd_front #(
      .TAPS(TAPS), .OVERSAMPLE(OVERSAMPLE), .SAMPLE_BITS(SAMPLE_BITS)
   ) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(req_ready),
      .in_i(req_sample_i), .in_q(req_sample_q),
      .pn_pattern(pattern_ff),
      .out_valid(f_valid), .out_ready(f_ready), .out_data(f_data)
   );

   // Queue between correlator and detector.
   pcpd_queue #(.WIDTH(QW)) u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
      .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
   );

   // Peak detector back end.
   pcpd_back #(
      .TAPS(TAPS), .OVERSAMPLE(OVERSAMPLE), .SAMPLE_BITS(SAMPLE_BITS)
   ) u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .in_valid(b_valid), .in_ready(b_ready), .in_data(b_data),
      .out_valid(rsp_valid), .out_ready(rsp_ready),
      .out_pass_i(rsp_pass_i), .out_pass_q(rsp_pass_q),
      .out_energy(rsp_corr_energy), .out_average(rsp_running_average),
      .out_found(rsp_peak_found), .out_position(rsp_peak_position)
   );

endmodule

>>> bench/pcpd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcpd_checker
// Watches the sample, result and register channels of the PN correlator,
// predicts every result from its own copy of the detector state, and
// compares each whole result with the prediction, counting the mismatches.
// ----------------------------------------------------------------------------
module pcpd_checker
   import pcpd_pkg::*;
#(
   parameter int TAPS        = 64,
   parameter int OVERSAMPLE  = 4,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_i,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_q,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic signed [SAMPLE_BITS-1:0] rsp_pass_i,
   input  logic signed [SAMPLE_BITS-1:0] rsp_pass_q,
   input  logic [ENERGY_W-1:0]           rsp_corr_energy,
   input  logic [ENERGY_W-1:0]           rsp_running_average,
   input  logic                          rsp_peak_found,
   input  logic [POS_W-1:0]              rsp_peak_position,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [63:0]                   csr_data,
   output int                            fail_count,
   output int                            pending_count
);

   localparam int DEPTH = TAPS * OVERSAMPLE;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] pass_i;
      logic signed [SAMPLE_BITS-1:0] pass_q;
      logic [ENERGY_W-1:0]           energy;
      logic [ENERGY_W-1:0]           average;
      logic                          found;
      logic [POS_W-1:0]              position;
   } pcpd_result_type;

   // Predicted detector state and register copies.
   logic [63:0]       pattern;
   logic [15:0]       alpha, rise;
   logic [LOOK_W-1:0] look;
   logic signed [SAMPLE_BITS-1:0] hist_i [DEPTH];
   logic signed [SAMPLE_BITS-1:0] hist_q [DEPTH];
   int unsigned       wr_pos;
   logic              searching, best_valid;
   logic [AVG_W-1:0]  avg_q16;
   logic [ENERGY_W-1:0] best_energy;
   logic [POS_W-1:0]  best_index, sample_count;
   int unsigned       countdown;
   pcpd_result_type   expected_results [$];

   assign pending_count = expected_results.size();

   // Advances the predicted detector by one sample and returns its result.
   function automatic pcpd_result_type predict_sample(
      logic signed [SAMPLE_BITS-1:0] xi, logic signed [SAMPLE_BITS-1:0] xq);
      pcpd_result_type r;
      longint si, sq;
      logic [127:0] sq_sum, lhs, rhs, mixed;
      logic [ENERGY_W-1:0] e;
      int unsigned k;
      si = 0;
      sq = 0;
      wr_pos = (wr_pos + 1) % DEPTH;
      hist_i[wr_pos] = xi;
      hist_q[wr_pos] = xq;
      for (int j = 0; j < TAPS; j++) begin
         k = (wr_pos + DEPTH - (DEPTH - 1 - j * OVERSAMPLE)) % DEPTH;
         if (pattern[j]) begin
            si += hist_i[k];
            sq += hist_q[k];
         end else begin
            si -= hist_i[k];
            sq -= hist_q[k];
         end
      end
      sq_sum = 128'(si * si) + 128'(sq * sq);
      e = (sq_sum > 128'((64'd1 << ENERGY_W) - 1)) ? '1 : sq_sum[ENERGY_W-1:0];
      r.found = 1'b0;
      r.position = '0;
      if (!searching) begin
         lhs = 128'(e) << 24;
         rhs = 128'(avg_q16) * (128'd256 + 128'(rise));
         if (lhs > rhs) begin
            searching = 1'b1;
            countdown = look;
            best_valid = 1'b0;
         end else begin
            // Exact truncating exponential average in Q36.16.
            mixed = (128'(alpha) * 128'(e) << 16)
                  + (128'd65536 - 128'(alpha)) * 128'(avg_q16);
            avg_q16 = AVG_W'(mixed >> 16);
         end
      end else begin
         if (!best_valid || e > best_energy) begin
            best_energy = e;
            best_valid = 1'b1;
            best_index = sample_count;
         end else if (countdown == 0) begin
            r.found = 1'b1;
            r.position = best_index + POS_W'(DEPTH);
            searching = 1'b0;
            avg_q16 = AVG_W'(e) << 16;
         end
         if (countdown > 0) countdown--;
      end
      r.pass_i = xi;
      r.pass_q = xq;
      r.energy = e;
      r.average = avg_q16[16 +: ENERGY_W];
      sample_count++;
      return r;
   endfunction

   // Tracks the three channels and compares each result with the oldest one due.
   always @(posedge clock) begin
      pcpd_result_type want, got;
      if (reset) begin
         pattern = '0;
         alpha = 16'd655;
         rise = 16'd25600;
         look = LOOK_W'(4);
         for (int n = 0; n < DEPTH; n++) begin
            hist_i[n] = '0;
            hist_q[n] = '0;
         end
         wr_pos = 0;
         searching = 1'b0;
         best_valid = 1'b0;
         avg_q16 = '0;
         best_energy = '0;
         best_index = '0;
         sample_count = '0;
         countdown = 0;
         fail_count = 0;
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_PN_PATTERN: pattern = csr_data;
               CSR_ALPHA:      alpha = csr_data[15:0];
               CSR_RISE:       rise = csr_data[15:0];
               CSR_LOOK_AHEAD: look = csr_data[LOOK_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_results.push_back(predict_sample(req_sample_i, req_sample_q));
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_pass_i, rsp_pass_q, rsp_corr_energy, rsp_running_average,
                    rsp_peak_found, rsp_peak_position};
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected item, actual %p", $time, got);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives samples and register writes into the PN correlator with random
// idling and back-pressure, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module testbench;
   import pcpd_pkg::*;

   localparam int SB = 12;
   localparam int SETTLE = 200;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready, csr_valid, csr_ready;
   logic signed [SB-1:0] req_sample_i, req_sample_q, rsp_pass_i, rsp_pass_q;
   logic [ENERGY_W-1:0] rsp_corr_energy, rsp_running_average;
   logic rsp_peak_found;
   logic [POS_W-1:0] rsp_peak_position;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [63:0] csr_data;
   int fail_count, pending_count;
   bit calm, hold_off;

   pn_correlator_peak_detector i_dut (.*);

   pcpd_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("Verification failed");
      $finish;
   end

   // Receiver: random stalls, plus one long hold-off that fills the block.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (400) @(negedge clock);
            hold_off = 1'b0;
         end
         rsp_ready <= calm || ($urandom_range(99) >= 11);
      end
   end

   task automatic write_reg(csr_index_type idx, logic [63:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic send_sample(logic signed [SB-1:0] si, logic signed [SB-1:0] sq);
      while (!calm && $urandom_range(99) < 11) @(negedge clock);
      req_valid = 1'b1;
      req_sample_i = si;
      req_sample_q = sq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // Waits until every predicted result has come back, then lets the block settle.
   task automatic drain();
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // Noise, then the last sixteen chips of the pattern aligned with the last
   // taps, so the detector crosses and peaks.
   task automatic send_burst(logic [63:0] pat, int amp, int noise);
      int n;
      n = $urandom_range(40, 20);
      for (int s = 0; s < n; s++)
         send_sample(SB'($signed($urandom_range(2 * noise)) - noise),
                     SB'($signed($urandom_range(2 * noise)) - noise));
      for (int j = 48; j < 64; j++)
         for (int o = 0; o < 4; o++)
            send_sample(o == 0 ? SB'(pat[j] ? amp : -amp) : SB'(0),
                        o == 0 ? SB'(pat[j] ? -amp / 2 : amp / 2) : SB'(0));
   endtask

   initial begin
      logic [63:0] pat;
      req_valid = 1'b0;
      csr_valid = 1'b0;
      req_sample_i = '0;
      req_sample_q = '0;
      csr_index = '0;
      csr_data = '0;
      calm = 1'b0;
      hold_off = 1'b0;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: field extremes under the reset settings, default pattern.
      send_sample(12'sh7FF, 12'sh800);
      send_sample(12'sh800, 12'sh7FF);
      send_sample(12'sh000, 12'shFFF);
      send_sample(12'sh555, 12'shAAA);
      for (int n = 0; n < 8; n++) send_sample(12'sh7FF, 12'sh7FF);
      drain();

      // Extremes: all-ones pattern, full weight, zero rise, no look-ahead.
      write_reg(CSR_PN_PATTERN, '1);
      write_reg(CSR_ALPHA, 16'hFFFF);
      write_reg(CSR_RISE, 16'h0000);
      write_reg(CSR_LOOK_AHEAD, '0);
      for (int n = 0; n < 12; n++) send_sample(n[0] ? 12'sh800 : 12'sh7FF, 12'sh800);
      drain();

      // Random phases over several settings, the last with a long receiver stall.
      for (int phase = 0; phase < 5; phase++) begin
         pat = {$urandom, $urandom};
         write_reg(CSR_PN_PATTERN, pat);
         write_reg(CSR_ALPHA, phase == 1 ? 16'd0 : 16'($urandom_range(65535)));
         write_reg(CSR_RISE, phase == 2 ? 16'hFFFF : 16'($urandom_range(2048)));
         write_reg(CSR_LOOK_AHEAD, phase == 3 ? 10'h3FF : 10'($urandom_range(12)));
         calm = (phase == 2);
         hold_off = (phase == 4);
         send_burst(pat, phase == 0 ? 2047 : $urandom_range(2047, 20), 40);
         for (int n = 0; n < 50; n++)
            send_sample(SB'($urandom), SB'($urandom));
         calm = 1'b0;
         drain();
      end

      if (fail_count == 0 && pending_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> pn_correlator_peak_detector.f
src/pcpd_pkg.sv
src/pcpd_front.sv
src/pcpd_queue.sv
src/pcpd_back.sv
src/pn_correlator_peak_detector.sv
bench/pcpd_checker.sv
bench/testbench.sv
